@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on every clock edge outside reset.
`define JSU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that an expression never holds outside reset.
`define JSU_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

@@ hw/rtl/jsu_pkg.sv @@
// ----------------------------------------------------------------------------
// JSON string unescape package
// Request and result types, status and error codes, buffer sizing.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] byte_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] data_out;
    logic [3:0] error_kind;
    logic       last;
  } out_item_t;

  localparam logic [1:0] ActData    = 2'd0;
  localparam logic [1:0] ActEnd     = 2'd1;
  localparam logic [1:0] ActRestart = 2'd2;

  localparam logic [1:0] StData  = 2'd0;
  localparam logic [1:0] StDone  = 2'd1;
  localparam logic [1:0] StError = 2'd2;

  localparam logic [3:0] ErrNone            = 4'd0;
  localparam logic [3:0] ErrNoQuote         = 4'd1;
  localparam logic [3:0] ErrControlChar     = 4'd2;
  localparam logic [3:0] ErrUnfinishedEsc   = 4'd3;
  localparam logic [3:0] ErrBadEscape       = 4'd4;
  localparam logic [3:0] ErrBadUnicode      = 4'd5;
  localparam logic [3:0] ErrMissingLow      = 4'd6;
  localparam logic [3:0] ErrBadLow          = 4'd7;
  localparam logic [3:0] ErrUnexpectedLow   = 4'd8;
  localparam logic [3:0] ErrUnterminated    = 4'd9;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned FifoDepth  = 8;
  localparam int unsigned PtrW       = 3;
  localparam int unsigned CntW       = 4;
  localparam int unsigned NumW       = 3;

  // Returns {valid, value} for an ASCII hex digit.
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/jsu_stream_if.sv @@
// ----------------------------------------------------------------------------
// JSON string unescape stream interface
// Valid/ready channel carrying one request or result per transfer.
// ----------------------------------------------------------------------------
interface jsu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/json_string_unescape_unit.sv @@
// ----------------------------------------------------------------------------
// JSON string unescape unit
// Decodes one quoted JSON string into UTF-8 bytes, completion or error.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries requests: action (data byte, end of input, restart) and
//         byte_in. Send the opening quote first; restart before each string.
//   out_o carries results: status, data_out, error_kind and last, where last
//         marks the final result of a request. A request yields 0 to 4 results.
//   Each accepted request is decoded in the cycle it is taken; its results
//   enter an 8-entry result buffer and, if the buffer was empty, the first
//   shows on out_o in the next cycle. One request per cycle is taken while
//   the buffer has room for four results. The buffer drains one result per
//   cycle while out_o.ready is high, so requests flow back to back while
//   they average at most one result each; each result takes its own drain.
//   When the receiver stalls, results stay in the buffer and in_i.ready drops
//   once fewer than four entries are free.
//   Reset empties the buffer and returns the decoder to waiting for the
//   opening quote. After completion or an error, data and end requests give
//   no result until a restart.
// ----------------------------------------------------------------------------
module json_string_unescape_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  jsu_stream_if.sink    in_i,
  jsu_stream_if.source  out_o
);

  localparam logic [3:0] PhQuote  = 4'd0;
  localparam logic [3:0] PhString = 4'd1;
  localparam logic [3:0] PhEscape = 4'd2;
  localparam logic [3:0] PhHex1   = 4'd3;
  localparam logic [3:0] PhWantBs = 4'd4;
  localparam logic [3:0] PhWantU  = 4'd5;
  localparam logic [3:0] PhHex2   = 4'd6;
  localparam logic [3:0] PhDone   = 4'd7;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChB = 8'h62;
  localparam logic [7:0] ChF = 8'h66;
  localparam logic [7:0] ChN = 8'h6e;
  localparam logic [7:0] ChR = 8'h72;
  localparam logic [7:0] ChT = 8'h74;
  localparam logic [7:0] ChU = 8'h75;

  logic [3:0]  phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  digits_q, digits_d;
  logic [9:0]  sur_q, sur_d;

  jsu_pkg::out_item_t mem_q [jsu_pkg::FifoDepth];
  logic [jsu_pkg::PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [jsu_pkg::CntW-1:0] count_q;

  logic                     in_fire, out_fire;
  jsu_pkg::out_item_t       res [jsu_pkg::MaxResults];
  logic [jsu_pkg::NumW-1:0] n_res;
  logic                     fail, done, emit, single;
  logic [3:0]               fail_kind;
  logic [7:0]               single_byte;
  logic [20:0]              cp;
  logic [4:0]               hexd;
  logic [15:0]              hex_v;
  logic [7:0]               c;

  assign in_i.ready = count_q <= jsu_pkg::CntW'(jsu_pkg::FifoDepth - jsu_pkg::MaxResults);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_o.valid   = count_q != '0;
  assign out_o.payload = mem_q[rd_ptr_q];
  assign out_fire      = out_o.valid && out_o.ready;

  assign c     = in_i.payload.byte_in;
  assign hexd  = jsu_pkg::hex_digit(c);
  assign hex_v = {acc_q[11:0], hexd[3:0]};

  always_comb begin
    phase_d     = phase_q;
    acc_d       = acc_q;
    digits_d    = digits_q;
    sur_d       = sur_q;
    fail        = 1'b0;
    fail_kind   = jsu_pkg::ErrNone;
    done        = 1'b0;
    emit        = 1'b0;
    single      = 1'b0;
    single_byte = '0;
    cp          = '0;
    if (in_fire) begin
      unique case (in_i.payload.action)
        jsu_pkg::ActData: begin
          unique case (phase_q)
            PhQuote: begin
              if (c != ChQuote) begin
                fail = 1'b1; fail_kind = jsu_pkg::ErrNoQuote;
              end else begin
                phase_d = PhString;
              end
            end
            PhString: begin
              priority if (c == ChQuote) begin
                done = 1'b1;
              end else if (c < ChSpace) begin
                fail = 1'b1; fail_kind = jsu_pkg::ErrControlChar;
              end else if (c == ChBslash) begin
                phase_d = PhEscape;
              end else begin
                single = 1'b1; single_byte = c;
              end
            end
            PhEscape: begin
              phase_d = PhString;
              if (c == ChQuote || c == ChBslash || c == ChSlash) begin
                single = 1'b1; single_byte = c;
              end else if (c == ChB) begin
                single = 1'b1; single_byte = 8'h08;
              end else if (c == ChF) begin
                single = 1'b1; single_byte = 8'h0c;
              end else if (c == ChN) begin
                single = 1'b1; single_byte = 8'h0a;
              end else if (c == ChR) begin
                single = 1'b1; single_byte = 8'h0d;
              end else if (c == ChT) begin
                single = 1'b1; single_byte = 8'h09;
              end else if (c == ChU) begin
                phase_d = PhHex1; acc_d = '0; digits_d = '0;
              end else begin
                fail = 1'b1; fail_kind = jsu_pkg::ErrBadEscape;
              end
            end
            PhHex1, PhHex2: begin
              if (!hexd[4]) begin
                fail = 1'b1;
                fail_kind = (phase_q == PhHex1) ? jsu_pkg::ErrBadUnicode : jsu_pkg::ErrBadLow;
              end else begin
                acc_d = hex_v;
                if (digits_q != 2'd3) begin
                  digits_d = digits_q + 2'd1;
                end else begin
                  digits_d = '0;
                  if (phase_q == PhHex1) begin
                    priority if (hex_v[15:10] == 6'b110110) begin
                      sur_d = hex_v[9:0]; phase_d = PhWantBs;
                    end else if (hex_v[15:10] == 6'b110111) begin
                      fail = 1'b1; fail_kind = jsu_pkg::ErrUnexpectedLow;
                    end else begin
                      phase_d = PhString; emit = 1'b1; cp = {5'd0, hex_v};
                    end
                  end else begin
                    if (hex_v[15:10] != 6'b110111) begin
                      fail = 1'b1; fail_kind = jsu_pkg::ErrBadLow;
                    end else begin
                      phase_d = PhString; emit = 1'b1;
                      cp = 21'h10000 + {1'b0, sur_q, hex_v[9:0]};
                    end
                  end
                end
              end
            end
            PhWantBs: begin
              if (c != ChBslash) begin
                fail = 1'b1; fail_kind = jsu_pkg::ErrMissingLow;
              end else begin
                phase_d = PhWantU;
              end
            end
            PhWantU: begin
              if (c != ChU) begin
                fail = 1'b1; fail_kind = jsu_pkg::ErrMissingLow;
              end else begin
                phase_d = PhHex2; acc_d = '0; digits_d = '0;
              end
            end
            default: ;
          endcase
        end
        jsu_pkg::ActEnd: begin
          unique case (phase_q)
            PhQuote:           begin fail = 1'b1; fail_kind = jsu_pkg::ErrNoQuote; end
            PhString:          begin fail = 1'b1; fail_kind = jsu_pkg::ErrUnterminated; end
            PhEscape:          begin fail = 1'b1; fail_kind = jsu_pkg::ErrUnfinishedEsc; end
            PhHex1:            begin fail = 1'b1; fail_kind = jsu_pkg::ErrBadUnicode; end
            PhWantBs, PhWantU: begin fail = 1'b1; fail_kind = jsu_pkg::ErrMissingLow; end
            PhHex2:            begin fail = 1'b1; fail_kind = jsu_pkg::ErrBadLow; end
            default: ;
          endcase
        end
        jsu_pkg::ActRestart: begin
          phase_d  = PhQuote;
          acc_d    = '0;
          digits_d = '0;
          sur_d    = '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < jsu_pkg::MaxResults; k++) begin
      res[k] = '{status: jsu_pkg::StData, data_out: 8'h00, error_kind: jsu_pkg::ErrNone,
                 last: 1'b0};
    end
    n_res = '0;
    if (fail) begin
      res[0].status     = jsu_pkg::StError;
      res[0].error_kind = fail_kind;
      n_res = 3'd1;
    end else if (done) begin
      res[0].status = jsu_pkg::StDone;
      n_res = 3'd1;
    end else if (single) begin
      res[0].data_out = single_byte;
      n_res = 3'd1;
    end else if (emit) begin
      priority if (cp <= 21'h7f) begin
        res[0].data_out = cp[7:0];
        n_res = 3'd1;
      end else if (cp <= 21'h7ff) begin
        res[0].data_out = {3'b110, cp[10:6]};
        res[1].data_out = {2'b10, cp[5:0]};
        n_res = 3'd2;
      end else if (cp <= 21'hffff) begin
        res[0].data_out = {4'b1110, cp[15:12]};
        res[1].data_out = {2'b10, cp[11:6]};
        res[2].data_out = {2'b10, cp[5:0]};
        n_res = 3'd3;
      end else begin
        res[0].data_out = {5'b11110, cp[20:18]};
        res[1].data_out = {2'b10, cp[17:12]};
        res[2].data_out = {2'b10, cp[11:6]};
        res[3].data_out = {2'b10, cp[5:0]};
        n_res = 3'd4;
      end
    end
    if (n_res != '0) begin
      res[2'(n_res - 3'd1)].last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhQuote;
      acc_q    <= '0;
      digits_q <= '0;
      sur_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      phase_q  <= (fail || done) ? PhDone : phase_d;
      acc_q    <= acc_d;
      digits_q <= digits_d;
      sur_q    <= sur_d;
      wr_ptr_q <= wr_ptr_q + jsu_pkg::PtrW'(n_res);
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + jsu_pkg::PtrW'(1);
      end
      count_q <= count_q + jsu_pkg::CntW'(n_res) - jsu_pkg::CntW'(out_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < jsu_pkg::MaxResults; k++) begin
      if (jsu_pkg::NumW'(k) < n_res) begin
        mem_q[wr_ptr_q + jsu_pkg::PtrW'(k)] <= res[k];
      end
    end
  end

endmodule

@@ hw/rtl/jsu_checker.sv @@
// ----------------------------------------------------------------------------
// JSON string unescape checker
// Port-level checks on the result channel, bound to json_string_unescape_unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input jsu_pkg::out_item_t out_item_i
);

  `JSU_ASSERT(a_stall_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i), "result changed while stalled")
  `JSU_ASSERT(a_data_fields, out_valid_i && out_item_i.status == jsu_pkg::StData |-> out_item_i.error_kind == jsu_pkg::ErrNone, "data result carries an error kind")
  `JSU_ASSERT(a_end_single, out_valid_i && out_item_i.status != jsu_pkg::StData |-> out_item_i.last && out_item_i.data_out == 8'h00, "end result not alone or carries data")
  `JSU_ASSERT_NEVER(a_bad_error, out_valid_i && out_item_i.status == jsu_pkg::StError && (out_item_i.error_kind == jsu_pkg::ErrNone || out_item_i.error_kind > jsu_pkg::ErrUnterminated), "error result with invalid kind")
  `JSU_ASSERT_NEVER(a_bad_status, out_valid_i && out_item_i.status != jsu_pkg::StData && out_item_i.status != jsu_pkg::StDone && out_item_i.status != jsu_pkg::StError, "undefined status code")

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.payload)
);
